[src/tkst_pkg.sv]
// Shared types and constants for the top-k score table.
`timescale 1ns / 1ps

package tkst_pkg;

    localparam int SCORE_W  = 32;
    localparam int STAMP_W  = 32;
    localparam int PLAYER_W = 16;
    localparam int RANK_W   = 4;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    typedef struct packed {
        logic [SCORE_W-1:0]  score;
        logic [STAMP_W-1:0]  stamp;
        logic [PLAYER_W-1:0] player;
    } t_rec;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_RDOUT
    } t_state;

endpackage

[src/tkst_ram.sv]
// Record memory of the score table: one write port, one registered read port.
`timescale 1ns / 1ps

module tkst_ram #(
    parameter int DEPTH = 10,
    parameter int AW    = 4
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  tkst_pkg::t_rec i_wdata,
    input  logic [AW-1:0]  i_raddr,
    output tkst_pkg::t_rec o_rdata
);
    import tkst_pkg::*;

    t_rec r_mem [DEPTH];
    t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/top_k_score_table_insert_core.sv]
// Top level of the top-k score table: sequencer, shared compare and result register.
`timescale 1ns / 1ps

// Score table kept in descending score order, ties in arrival order.
// Command channel: a beat is taken at a clock edge with start high and busy
// low. i_action selects insert (score, stamp, player id) or read (rank index).
// Result channel: one beat per command, valid for exactly one cycle while
// o_strobe is high; the receiver cannot stall it and the block never waits.
// Insert: the table is walked from the lowest record upward, one record a
// cycle through the single read port of the record memory and one shared
// score comparator; each lower record is moved down one slot as it passes.
// The scan examines the records below the new rank, plus one if the new
// rank is not the top; busy stays high through the scan and the place step,
// and o_strobe rises on the cycle busy falls. Read of a held rank: busy
// through the read-out state; the record passes the memory read register
// and the result register. Empty rank read: result on the next cycle, busy stays low.
// A full table drops the lowest record; a dropped insert reports rank
// MAX_ENTRIES. Reset empties the table at once; no clearing pass.
module top_k_score_table_insert_core #(
    parameter int MAX_ENTRIES = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_action,
    input  logic [tkst_pkg::SCORE_W-1:0]  i_score,
    input  logic [tkst_pkg::STAMP_W-1:0]  i_stamp,
    input  logic [tkst_pkg::PLAYER_W-1:0] i_player_id,
    input  logic [tkst_pkg::RANK_W-1:0]   i_rank_index,
    output logic                      o_strobe,
    output logic [tkst_pkg::RANK_W-1:0]   o_placed_rank,
    output logic [tkst_pkg::RANK_W-1:0]   o_entry_count,
    output logic                      o_read_valid,
    output logic [tkst_pkg::SCORE_W-1:0]  o_read_score,
    output logic [tkst_pkg::STAMP_W-1:0]  o_read_stamp,
    output logic [tkst_pkg::PLAYER_W-1:0] o_read_player
);
    import tkst_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int WW = (CW > RANK_W) ? CW : RANK_W;
    localparam logic [CW-1:0]     MAX_C    = CW'(MAX_ENTRIES);
    localparam logic [RANK_W-1:0] DROP_RNK = RANK_W'(MAX_ENTRIES);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_pos, n_pos;
    t_rec            r_new;

    logic              r_o_strobe, n_o_strobe;
    logic [RANK_W-1:0] r_o_placed, n_o_placed;
    logic [RANK_W-1:0] r_o_count, n_o_count;
    logic              r_o_rvalid, n_o_rvalid;
    t_rec              r_o_rec, n_o_rec;

    logic          w_accept;
    logic          w_rank_hit;
    logic          w_ge;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    t_rec          w_wdata;
    t_rec          w_rdata;

    tkst_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign busy       = (r_state != ST_IDLE);
    assign w_accept   = start && !busy;
    assign w_rank_hit = WW'(i_rank_index) < WW'(r_count);
    assign w_ge       = (w_rdata.score >= r_new.score);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_READ) begin
                        n_state = w_rank_hit ? ST_RDOUT : ST_IDLE;
                    end else begin
                        n_state = (r_count == '0) ? ST_PLACE : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (w_ge || (r_idx == CW'(1))) begin
                    n_state = ST_PLACE;
                end
            end
            ST_PLACE: n_state = ST_IDLE;
            ST_RDOUT: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count    = r_count;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_o_strobe = 1'b0;
        n_o_placed = r_o_placed;
        n_o_count  = r_o_count;
        n_o_rvalid = r_o_rvalid;
        n_o_rec    = r_o_rec;
        w_we       = 1'b0;
        w_waddr    = AW'(r_idx);
        w_wdata    = w_rdata;
        w_raddr    = AW'(r_idx - 1'b1);
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_READ) begin
                        w_raddr = AW'(i_rank_index);
                        if (!w_rank_hit) begin
                            n_o_strobe = 1'b1;
                            n_o_placed = DROP_RNK;
                            n_o_count  = RANK_W'(r_count);
                            n_o_rvalid = 1'b0;
                            n_o_rec    = '0;
                        end
                    end else begin
                        n_idx   = r_count;
                        n_pos   = '0;
                        w_raddr = AW'(r_count - 1'b1);
                    end
                end
            end
            ST_SCAN: begin
                if (w_ge) begin
                    n_pos = r_idx;
                end else begin
                    w_we    = (r_idx < MAX_C);
                    w_waddr = AW'(r_idx);
                    w_wdata = w_rdata;
                    w_raddr = AW'(r_idx - 1'b1 - 1'b1);
                    n_idx   = r_idx - 1'b1;
                    n_pos   = '0;
                end
            end
            ST_PLACE: begin
                w_we       = (r_pos < MAX_C);
                w_waddr    = AW'(r_pos);
                w_wdata    = r_new;
                if (r_count < MAX_C) begin
                    n_count = r_count + 1'b1;
                end
                n_o_strobe = 1'b1;
                n_o_placed = RANK_W'(r_pos);
                n_o_count  = (r_count < MAX_C) ? RANK_W'(r_count + 1'b1) : RANK_W'(r_count);
                n_o_rvalid = 1'b0;
                n_o_rec    = '0;
            end
            ST_RDOUT: begin
                n_o_strobe = 1'b1;
                n_o_placed = DROP_RNK;
                n_o_count  = RANK_W'(r_count);
                n_o_rvalid = 1'b1;
                n_o_rec    = w_rdata;
            end
            default: begin
                n_o_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_o_strobe <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_o_strobe <= n_o_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_o_placed <= n_o_placed;
        r_o_count  <= n_o_count;
        r_o_rvalid <= n_o_rvalid;
        r_o_rec    <= n_o_rec;
        if (w_accept) begin
            r_new <= '{score: i_score, stamp: i_stamp, player: i_player_id};
        end
    end

    assign o_strobe      = r_o_strobe;
    assign o_placed_rank = r_o_placed;
    assign o_entry_count = r_o_count;
    assign o_read_valid  = r_o_rvalid;
    assign o_read_score  = r_o_rec.score;
    assign o_read_stamp  = r_o_rec.stamp;
    assign o_read_player = r_o_rec.player;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_C)
        else $error("record count above table size");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_state == ST_IDLE))
        else $error("result beat while sequencer active");

    a_read_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_action == ACT_READ) && !w_rank_hit) |=>
            (o_strobe && !o_read_valid))
        else $error("read of empty rank gave no immediate result");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx != '0))
        else $error("scan index ran past the top record");

    a_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && (r_state == ST_SCAN)) |-> (w_waddr != w_raddr))
        else $error("record move collides with next read");

endmodule
